[hdl/spsc_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper packet step controller package
// Shared item types, framing states, protocol codes and the half-step
// coil table.
// ----------------------------------------------------------------------------
package spsc_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  coil_pattern;
    logic        step_taken;
    logic        stepping_active;
    logic [15:0] position;
    logic [15:0] target_position;
    logic        packet_done;
  } out_item_t;

  typedef enum logic [2:0] {
    FRM_WAIT   = 3'd0,
    FRM_FIRST  = 3'd1,
    FRM_SECOND = 3'd2,
    FRM_ESCAPE = 3'd3,
    FRM_DONE   = 3'd4
  } frame_state_e;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] OPCODE_A   = 8'd3;
  localparam logic [7:0] OPCODE_B   = 8'd4;
  localparam logic [7:0] ESC_SECOND = 8'd1;
  localparam logic [7:0] ESC_FIRST  = 8'd2;
  localparam logic [7:0] ESC_BOTH   = 8'd3;
  localparam logic [7:0] ESC_VALUE  = 8'hFF;

  localparam logic [15:0] INTERVAL_RESET = 16'h1AFF;
  localparam logic [15:0] TARGET_RESET   = 16'd1000;

  function automatic logic [3:0] coil_lookup(input logic [2:0] phase);
    logic [3:0] pattern;
    case (phase)
      3'd0:    pattern = 4'h1;
      3'd1:    pattern = 4'h3;
      3'd2:    pattern = 4'h2;
      3'd3:    pattern = 4'h6;
      3'd4:    pattern = 4'h4;
      3'd5:    pattern = 4'hC;
      3'd6:    pattern = 4'h8;
      3'd7:    pattern = 4'h9;
      default: pattern = 4'h0;
    endcase
    return pattern;
  endfunction

endpackage

[hdl/spsc_stream_if.sv]
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel carrying valid, ready and a typed payload. A transfer
// happens at a rising clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface spsc_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

[hdl/stepper_packet_step_controller_top.sv]
// ----------------------------------------------------------------------------
// Stepper packet step controller
// Framed serial packets set step interval and target; timer ticks drive a
// half-step coil sequencer toward the target.
// ----------------------------------------------------------------------------
// Each transfer on item_i is either a received byte or a timer tick, and each
// yields exactly one result on result_o. The block takes one item per clock
// cycle while result_o is not stalled: an input register holds the item, and
// the framing and stepping updates are computed from it in a single pass into
// the result register. The input register accepts a new item whenever it is
// empty, or when the result register is empty or is being drained in the same
// cycle.
module stepper_packet_step_controller_top
  import spsc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  spsc_stream_if.sink               item_i,
  spsc_stream_if.source             result_o
);

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  out_item_t  out_item_d;
  logic       advance;
  logic       fire;

  frame_state_e frame_state_q, frame_state_d;
  logic         start_seen_q, start_seen_d;
  logic [7:0]   first_data_q, first_data_d;
  logic [7:0]   second_data_q, second_data_d;
  logic [15:0]  interval_q, interval_d;
  logic [15:0]  target_q, target_d;
  logic [15:0]  count_q, count_d;
  logic [2:0]   phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic         enable_q, enable_d;
  logic [3:0]   coil_q, coil_d;

  logic [TIMER_WIDTH-1:0] timer_inc;
  logic [TIMER_WIDTH-1:0] interval_cmp;
  logic [47:0]            interval_ext;
  logic                   is_tick;
  logic                   is_byte;
  logic [7:0]             rx;
  logic                   match;
  logic                   step_now;
  logic                   packet_now;
  logic [7:0]             first_eff;
  logic [7:0]             second_eff;

  assign advance      = !out_valid_q || result_o.ready;
  assign fire         = in_valid_q && advance;
  assign item_i.ready = !in_valid_q || advance;

  assign is_tick = (in_item_q.command == CMD_TICK);
  assign is_byte = (in_item_q.command == CMD_BYTE);
  assign rx      = in_item_q.rx_byte;

  // Framing state transitions.
  always_comb begin
    frame_state_d = frame_state_q;
    if (is_byte) begin
      if (rx == START_BYTE || frame_state_q == FRM_DONE) begin
        frame_state_d = FRM_WAIT;
      end else if ((rx == OPCODE_A || rx == OPCODE_B) && frame_state_q == FRM_WAIT &&
                   start_seen_q) begin
        frame_state_d = FRM_FIRST;
      end else begin
        case (frame_state_q)
          FRM_FIRST:  frame_state_d = FRM_SECOND;
          FRM_SECOND: frame_state_d = FRM_ESCAPE;
          FRM_ESCAPE: frame_state_d = FRM_DONE;
          default:    frame_state_d = frame_state_q;
        endcase
      end
    end
  end

  // Framing data path and packet application.
  always_comb begin
    start_seen_d  = start_seen_q;
    first_data_d  = first_data_q;
    second_data_d = second_data_q;
    packet_now    = 1'b0;
    first_eff     = first_data_q;
    second_eff    = second_data_q;
    if (rx == ESC_SECOND || rx == ESC_BOTH) begin
      second_eff = ESC_VALUE;
    end
    if (rx == ESC_FIRST || rx == ESC_BOTH) begin
      first_eff = ESC_VALUE;
    end
    if (is_byte) begin
      if (rx == START_BYTE || frame_state_q == FRM_DONE) begin
        start_seen_d = 1'b1;
      end else if ((rx == OPCODE_A || rx == OPCODE_B) && frame_state_q == FRM_WAIT &&
                   start_seen_q) begin
        start_seen_d = 1'b0;
      end else begin
        case (frame_state_q)
          FRM_FIRST:  first_data_d = rx;
          FRM_SECOND: second_data_d = rx;
          FRM_ESCAPE: begin
            first_data_d  = first_eff;
            second_data_d = second_eff;
            packet_now    = 1'b1;
          end
          default:    start_seen_d = 1'b0;
        endcase
      end
    end
  end

  assign interval_ext = {32'd0, interval_q};
  assign interval_cmp = interval_ext[TIMER_WIDTH-1:0];
  assign timer_inc    = timer_q + {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
  assign match        = is_tick && enable_q && (timer_inc == interval_cmp);
  assign step_now     = match && (target_q != count_q);

  // Stepping path.
  always_comb begin
    interval_d = interval_q;
    target_d   = target_q;
    count_d    = count_q;
    phase_d    = phase_q;
    timer_d    = timer_q;
    enable_d   = enable_q;
    coil_d     = coil_q;
    if (packet_now) begin
      interval_d = {first_eff, 8'd0};
      target_d   = {8'd0, second_eff};
      enable_d   = 1'b1;
    end
    if (is_tick) begin
      timer_d = timer_inc;
      if (match && !step_now) begin
        enable_d = 1'b0;
      end
      if (step_now) begin
        coil_d  = coil_lookup(phase_q);
        timer_d = '0;
        if (target_q < count_q) begin
          phase_d = phase_q - 3'd1;
          count_d = count_q - 16'd1;
        end else begin
          phase_d = phase_q + 3'd1;
          count_d = count_q + 16'd1;
        end
      end
    end
  end

  always_comb begin
    out_item_d.coil_pattern    = coil_d;
    out_item_d.step_taken      = step_now;
    out_item_d.stepping_active = enable_d;
    out_item_d.position        = count_d;
    out_item_d.target_position = target_d;
    out_item_d.packet_done     = packet_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      frame_state_q <= FRM_WAIT;
      start_seen_q  <= 1'b0;
      first_data_q  <= 8'd0;
      second_data_q <= 8'd0;
      interval_q    <= INTERVAL_RESET;
      target_q      <= TARGET_RESET;
      count_q       <= 16'd0;
      phase_q       <= 3'd0;
      timer_q       <= '0;
      enable_q      <= 1'b1;
      coil_q        <= 4'd0;
    end else begin
      if (item_i.ready) begin
        in_valid_q <= item_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        frame_state_q <= frame_state_d;
        start_seen_q  <= start_seen_d;
        first_data_q  <= first_data_d;
        second_data_q <= second_data_d;
        interval_q    <= interval_d;
        target_q      <= target_d;
        count_q       <= count_d;
        phase_q       <= phase_d;
        timer_q       <= timer_d;
        enable_q      <= enable_d;
        coil_q        <= coil_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      in_item_q <= item_i.payload;
    end
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_item_q;

  a_step_clears_timer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && step_now |=> timer_q == '0)
    else $error("Timer not cleared after a step.");

  a_stop_only_at_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && enable_q && !enable_d |-> target_q == count_q)
    else $error("Stepping stopped away from the target.");

  a_step_xor_packet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.step_taken && out_item_q.packet_done))
    else $error("One item both stepped and completed a packet.");

  a_packet_enables : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.packet_done |-> out_item_q.stepping_active)
    else $error("Completed packet did not enable stepping.");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> out_valid_q && $stable(out_item_q))
    else $error("Pending result changed before its transfer.");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper packet step controller testbench
// Drives received bytes and timer ticks into the block over a valid/ready
// channel and checks every result against a cycle-free model of the framing
// machine and the half-step sequencer. A short directed run covers framing
// corner cases and every escape code. A random run then sends mostly
// well-formed packets, sized from the model state so that steps and stops
// actually happen, mixed with noise bytes and broken frames. Both sides of
// the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb
  import spsc_pkg::*;
();

  localparam int RANDOM_ITEMS   = 1650;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;

  class stepper_scoreboard;
    frame_state_e frame;
    bit           start_seen;
    logic [7:0]   first_data;
    logic [7:0]   second_data;
    logic [15:0]  interval;
    logic [15:0]  target;
    logic [15:0]  position;
    logic [15:0]  timer;
    logic [2:0]   phase;
    bit           enable;
    logic [3:0]   coil;
    logic [3:0]   coil_seq [8];
    out_item_t    pending_results [$];
    int           errors;
    int           checked;
    int           ticks;
    int           bytes_seen;
    int           packets;
    int           steps_up;
    int           steps_down;
    int           stops;

    function new();
      coil_seq    = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
      frame       = FRM_WAIT;
      start_seen  = 1'b0;
      first_data  = '0;
      second_data = '0;
      interval    = INTERVAL_RESET;
      target      = TARGET_RESET;
      position    = '0;
      timer       = '0;
      phase       = '0;
      enable      = 1'b1;
      coil        = '0;
    endfunction

    function void apply_item(in_item_t it);
      out_item_t want;
      logic      stepped;
      logic      done;
      logic [7:0] b;
      stepped = 1'b0;
      done    = 1'b0;
      b       = it.rx_byte;
      if (it.command == CMD_TICK) begin
        ticks++;
        timer = timer + 16'd1;
        if (enable && timer == interval) begin
          if (target == position) begin
            enable = 1'b0;
            stops++;
          end else begin
            coil = coil_seq[phase];
            if (target < position) begin
              phase    = phase - 3'd1;
              position = position - 16'd1;
              steps_down++;
            end else begin
              phase    = phase + 3'd1;
              position = position + 16'd1;
              steps_up++;
            end
            timer   = '0;
            stepped = 1'b1;
          end
        end
      end else begin
        bytes_seen++;
        if (b == START_BYTE || frame == FRM_DONE) begin
          frame      = FRM_WAIT;
          start_seen = 1'b1;
        end else if ((b == OPCODE_A || b == OPCODE_B) && frame == FRM_WAIT && start_seen) begin
          start_seen = 1'b0;
          frame      = FRM_FIRST;
        end else if (frame == FRM_FIRST) begin
          first_data = b;
          frame      = FRM_SECOND;
        end else if (frame == FRM_SECOND) begin
          second_data = b;
          frame       = FRM_ESCAPE;
        end else if (frame == FRM_ESCAPE) begin
          if (b == ESC_SECOND || b == ESC_BOTH) second_data = ESC_VALUE;
          if (b == ESC_FIRST || b == ESC_BOTH) first_data = ESC_VALUE;
          interval = {first_data, 8'h00};
          target   = {8'h00, second_data};
          enable   = 1'b1;
          frame    = FRM_DONE;
          done     = 1'b1;
          packets++;
        end else begin
          start_seen = 1'b0;
        end
      end
      want.coil_pattern    = coil;
      want.step_taken      = stepped;
      want.stepping_active = enable;
      want.position        = position;
      want.target_position = target;
      want.packet_done     = done;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with none pending, expected nothing, got 0x%0h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("coil_pattern", 16'(want.coil_pattern), 16'(got.coil_pattern));
      compare_field("step_taken", 16'(want.step_taken), 16'(got.step_taken));
      compare_field("stepping_active", 16'(want.stepping_active), 16'(got.stepping_active));
      compare_field("position", want.position, got.position);
      compare_field("target_position", want.target_position, got.target_position);
      compare_field("packet_done", 16'(want.packet_done), 16'(got.packet_done));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   sender_idle;

  stepper_scoreboard sb;

  spsc_stream_if #(.T(in_item_t))  item_if ();
  spsc_stream_if #(.T(out_item_t)) result_if ();

  stepper_packet_step_controller_top #(
    .TIMER_WIDTH(16)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(input logic cmd, input logic [7:0] value);
    in_item_t it;
    int       gap;
    it.command = cmd;
    it.rx_byte = value;
    gap = sender_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    do @(negedge clk_i); while (!item_if.ready);
    @(posedge clk_i);
    sb.apply_item(it);
  endtask

  task automatic send_byte(input logic [7:0] value);
    send_item(CMD_BYTE, value);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(CMD_TICK, 8'($urandom));
  endtask

  task automatic send_packet(input logic [7:0] lead, input logic [7:0] opcode,
                             input logic [7:0] first_byte, input logic [7:0] second_byte,
                             input logic [7:0] esc);
    send_byte(lead);
    send_byte(opcode);
    send_byte(first_byte);
    send_byte(second_byte);
    send_byte(esc);
  endtask

  task automatic wait_results_drained();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
  endtask

  task automatic run_directed();
    sender_idle = 1'b1;
    send_ticks(1);
    send_byte(8'h00);
    send_byte(OPCODE_A);
    send_packet(START_BYTE, OPCODE_A, 8'h01, 8'h00, ESC_BOTH);
    // Any byte right after a finished packet counts as a start byte.
    send_byte(8'h07);
    send_byte(OPCODE_B);
    send_byte(START_BYTE);
    send_byte(OPCODE_B);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(ESC_SECOND);
    send_packet(START_BYTE, OPCODE_B, 8'h00, 8'hFE, ESC_FIRST);
    send_packet(START_BYTE, OPCODE_A, 8'h80, 8'h7F, 8'h55);
  endtask

  task automatic run_random();
    int         goal;
    int         kind;
    int         count;
    int         first_val;
    int         second_val;
    int         spread;
    int         match_cnt;
    logic [7:0] lead;
    logic [7:0] esc;
    logic [7:0] b;
    goal = sb.ticks + sb.bytes_seen + RANDOM_ITEMS;
    while (sb.ticks + sb.bytes_seen < goal) begin
      sender_idle = $urandom_range(0, 2) != 0;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        lead = START_BYTE;
        if (sb.frame == FRM_DONE && $urandom_range(0, 3) == 0) lead = 8'($urandom_range(0, 254));
        // Pick the interval just above the running timer so the next match comes soon.
        first_val = int'(sb.timer >> 8) + 1;
        if (first_val > 254 || $urandom_range(0, 7) == 0) first_val = $urandom_range(0, 254);
        spread = $urandom_range(0, 2);
        second_val = $urandom_range(0, 1) ? int'(sb.position) + spread :
                     int'(sb.position) - spread;
        if (second_val < 0) second_val = 0;
        if (second_val > 254) second_val = 254;
        case ($urandom_range(0, 9))
          0:       esc = ESC_SECOND;
          1:       esc = ESC_FIRST;
          2:       esc = ESC_BOTH;
          3:       esc = START_BYTE;
          default: esc = 8'($urandom);
        endcase
        send_packet(lead, $urandom_range(0, 1) ? OPCODE_A : OPCODE_B, 8'(first_val),
                    8'(second_val), esc);
        if (sb.enable && sb.interval > sb.timer && sb.interval - sb.timer <= 16'd1024) begin
          spread = int'(sb.target) - int'(sb.position);
          if (spread < 0) spread = -spread;
          match_cnt = (spread > 2) ? 2 : spread;
          if ($urandom_range(0, 3) == 0) match_cnt++;
          if (match_cnt == 0) count = $urandom_range(0, 20);
          else count = int'(sb.interval - sb.timer) + (match_cnt - 1) * int'(sb.interval)
                       + $urandom_range(0, 20);
          if (count > 1200) count = 1200;
        end else begin
          count = $urandom_range(0, 40);
        end
        if (count > goal - (sb.ticks + sb.bytes_seen)) count = goal - (sb.ticks + sb.bytes_seen);
        if (count < 0) count = 0;
        send_ticks(count);
      end else if (kind < 8) begin
        count = $urandom_range(1, 8);
        repeat (count) begin
          case ($urandom_range(0, 5))
            0:       b = START_BYTE;
            1:       b = OPCODE_A;
            2:       b = OPCODE_B;
            3:       b = ESC_SECOND;
            4:       b = ESC_FIRST;
            default: b = 8'($urandom);
          endcase
          send_byte(b);
        end
      end else begin
        count = $urandom_range(1, 10);
        repeat (count) send_item(1'($urandom_range(0, 1)), 8'($urandom));
      end
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end
  endtask

  initial begin : result_sink
    int        stall;
    int        run_left;
    bit        sink_idle;
    out_item_t got;
    run_left  = 0;
    sink_idle = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (run_left == 0) begin
        sink_idle = $urandom_range(0, 2) != 0;
        run_left  = $urandom_range(20, 80);
      end
      run_left--;
      stall = sink_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(negedge clk_i); while (!result_if.valid);
      got = result_if.payload;
      @(posedge clk_i);
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
          rst_ni !== 1'b1) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t ns: timeout, no transfer for %0d cycles", $time, quiet);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sender_idle = 1'b0;
    rst_ni          <= 1'b0;
    item_if.valid   <= 1'b0;
    item_if.payload <= '0;
    result_if.ready <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_results_drained();
    run_random();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items (%0d bytes, %0d ticks); %0d packets completed, %0d results checked.",
             sb.ticks + sb.bytes_seen, sb.bytes_seen, sb.ticks, sb.packets, sb.checked);
    $display("Motor took %0d half-steps up, %0d down and stopped at target %0d times.",
             sb.steps_up, sb.steps_down, sb.stops);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
